/* rtl/core/rhad_pkg.sv */
// shared codes, field masks and types of the rtp h.264 / aac depacketizer
package rhad_pkg;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // codec modes
    localparam logic MODE_H264 = 1'b0;
    localparam logic MODE_AAC  = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_MALFORMED   = 3'd1;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd2;
    localparam logic [2:0] ST_OVERFLOW    = 3'd3;
    localparam logic [2:0] ST_EMPTY       = 3'd4;
    localparam logic [2:0] ST_FULL        = 3'd5;

    // rtp header fields
    localparam int RTP_FIXED_HDR = 12;
    localparam logic [7:0] RTP_CC_MASK = 8'h0f;
    localparam logic [7:0] RTP_EXT_BIT = 8'h10;
    localparam logic [7:0] RTP_PAD_BIT = 8'h20;

    // nal unit fields
    localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
    localparam logic [7:0] NAL_NRI_MASK  = 8'he0;
    localparam logic [7:0] FU_START_BIT  = 8'h80;
    localparam logic [7:0] FU_END_BIT    = 8'h40;
    localparam logic [4:0] NAL_IDR       = 5'd5;
    localparam logic [4:0] NAL_SPS       = 5'd7;
    localparam logic [4:0] NAL_PPS       = 5'd8;
    localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
    localparam logic [4:0] NAL_FU_A      = 5'd28;

    // per-unit metadata kept in the unit queue
    typedef struct packed {
        logic        key;
        logic [31:0] ts;
    } unit_meta_t;

endpackage

/* rtl/core/rhad_dgram.sv */
// datagram store with its byte count and overflow mark
module rhad_dgram #(
    parameter int MAX_DATAGRAM = 2048,
    localparam int DAW = $clog2(MAX_DATAGRAM),
    localparam int LW  = $clog2(MAX_DATAGRAM + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  logic [7:0]     wr_byte,
    input  logic           clear,
    input  logic [DAW-1:0] rd_addr,
    output logic [7:0]     rd_data,
    output logic [LW-1:0]  size,
    output logic           over
);
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_DATAGRAM);

    logic [7:0]    mem [MAX_DATAGRAM];
    logic [7:0]    rd_data_reg;
    logic [LW-1:0] len_reg, len_next;
    logic          over_reg, over_next;
    logic          room;

    assign room = (len_reg < MAX_LEN);

    // length and overflow mark
    always_comb
    begin
        len_next  = len_reg;
        over_next = over_reg;
        if (clear)
        begin
            len_next  = '0;
            over_next = 1'b0;
        end
        else if (wr_en)
        begin
            if (room)
                len_next = len_reg + 1'b1;
            else
                over_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            over_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            over_reg <= over_next;
        end
    end

    // byte memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en && room)
            mem[len_reg[DAW-1:0]] <= wr_byte;
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign size    = len_reg;
    assign over    = over_reg;

endmodule

/* rtl/core/rhad_outbuf.sv */
// output byte ring and unit queue with byte-wise readout
module rhad_outbuf #(
    parameter int OUTPUT_BYTES = 32768,
    parameter int OUTPUT_UNITS = 16,
    localparam int OAW = $clog2(OUTPUT_BYTES),
    localparam int OUW = $clog2(OUTPUT_BYTES + 1),
    localparam int QAW = (OUTPUT_UNITS > 1) ? $clog2(OUTPUT_UNITS) : 1,
    localparam int QCW = $clog2(OUTPUT_UNITS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [7:0]            wr_byte,
    input  logic                  push,
    input  logic [OUW-1:0]        push_len,
    input  rhad_pkg::unit_meta_t  push_meta,
    input  logic                  rd_req,
    output logic [QCW-1:0]        count,
    output logic [OUW-1:0]        used,
    output logic [7:0]            rd_byte,
    output logic                  rd_first,
    output logic                  rd_last,
    output rhad_pkg::unit_meta_t  rd_meta
);
    import rhad_pkg::*;

    localparam logic [OUW:0] OB_W   = (OUW + 1)'(OUTPUT_BYTES);
    localparam logic [QAW:0] UNIT_W = (QAW + 1)'(OUTPUT_UNITS);

    logic [7:0]     mem [OUTPUT_BYTES];
    logic [OAW-1:0] q_start [OUTPUT_UNITS];
    logic [OUW-1:0] q_len   [OUTPUT_UNITS];
    unit_meta_t     q_meta  [OUTPUT_UNITS];

    logic [OAW-1:0] wr_reg, wr_next;
    logic [OUW-1:0] used_reg, used_next;
    logic [QAW-1:0] head_reg, head_next;
    logic [QCW-1:0] count_reg, count_next;
    logic [OUW-1:0] offset_reg, offset_next;
    logic [7:0]     rd_byte_reg;
    logic           rd_first_reg, rd_last_reg;
    unit_meta_t     rd_meta_reg;

    logic [OUW:0]   wr_inc, pos_sum, pos_wrap;
    logic [QAW:0]   tail_sum, tail_wrap;
    logic [OAW-1:0] pos;
    logic [QAW-1:0] tail;
    logic [OUW-1:0] head_len;
    logic           is_last;

    // ring arithmetic
    assign wr_inc    = (OUW + 1)'(wr_reg) + 1'b1;
    assign pos_sum   = (OUW + 1)'(q_start[head_reg]) + (OUW + 1)'(offset_reg);
    assign pos_wrap  = (pos_sum >= OB_W) ? pos_sum - OB_W : pos_sum;
    assign pos       = pos_wrap[OAW-1:0];
    assign tail_sum  = (QAW + 1)'(head_reg) + (QAW + 1)'(count_reg);
    assign tail_wrap = (tail_sum >= UNIT_W) ? tail_sum - UNIT_W : tail_sum;
    assign tail      = tail_wrap[QAW-1:0];
    assign head_len  = q_len[head_reg];
    assign is_last   = ((offset_reg + 1'b1) >= head_len);

    // pointer and occupancy update
    always_comb
    begin
        wr_next     = wr_reg;
        used_next   = used_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        offset_next = offset_reg;
        if (wr_en)
            wr_next = (wr_inc >= OB_W) ? '0 : wr_inc[OAW-1:0];
        if (push)
        begin
            count_next = count_reg + 1'b1;
            used_next  = used_reg + push_len;
        end
        else if (rd_req)
        begin
            if (is_last)
            begin
                used_next   = (used_reg >= head_len) ? used_reg - head_len : '0;
                head_next   = (head_reg == QAW'(OUTPUT_UNITS - 1)) ? '0
                                                                   : head_reg + 1'b1;
                count_next  = count_reg - 1'b1;
                offset_next = '0;
            end
            else
                offset_next = offset_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg     <= '0;
            used_reg   <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
            offset_reg <= '0;
        end
        else
        begin
            wr_reg     <= wr_next;
            used_reg   <= used_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            offset_reg <= offset_next;
        end
    end

    // queue entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_start[tail] <= wr_reg;
            q_len[tail]   <= push_len;
            q_meta[tail]  <= push_meta;
        end
    end

    // byte memory and registered readout
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_reg] <= wr_byte;
        rd_byte_reg <= mem[pos];
        if (rd_req)
        begin
            rd_first_reg <= (offset_reg == '0);
            rd_last_reg  <= is_last;
            rd_meta_reg  <= q_meta[head_reg];
        end
    end

    assign count    = count_reg;
    assign used     = used_reg;
    assign rd_byte  = rd_byte_reg;
    assign rd_first = rd_first_reg;
    assign rd_last  = rd_last_reg;
    assign rd_meta  = rd_meta_reg;

endmodule

/* rtl/core/rtp_h264_aac_depacketizer.sv */
// top level: header parser, unit builder, assembly store and copy sequencer
//
// Command-style block: an item is taken when start is high and busy is low,
// and its one result appears on the result ports for a single cycle with
// done high; the receiver cannot stall it. A datagram byte write without
// the last mark is answered from the idle state. An output byte read passes
// through the read state, which waits for the registered output memory
// read. The last byte of a datagram starts the parse: header reads from
// the datagram memory and the unit decision, extension length reads for an
// extension header, then the copy phases, in which the single read port of
// each memory moves one byte a cycle.
module rtp_h264_aac_depacketizer #(
    parameter int MAX_DATAGRAM   = 2048,
    parameter int ASSEMBLY_BYTES = 16384,
    parameter int OUTPUT_BYTES   = 32768,
    parameter int OUTPUT_UNITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    output logic        done,
    output logic [2:0]  status,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        out_first,
    output logic        out_last,
    output logic        key_unit,
    output logic [31:0] unit_timestamp
);
    import rhad_pkg::*;

    localparam int DAW = $clog2(MAX_DATAGRAM);
    localparam int LW  = $clog2(MAX_DATAGRAM + 1);
    localparam int AAW = $clog2(ASSEMBLY_BYTES);
    localparam int ALW = $clog2(ASSEMBLY_BYTES + 1);
    localparam int OUW = $clog2(OUTPUT_BYTES + 1);
    localparam int QCW = $clog2(OUTPUT_UNITS + 1);
    localparam int CW  = (ALW > LW) ? ALW : LW;
    localparam int SW  = $clog2(ASSEMBLY_BYTES + MAX_DATAGRAM + OUTPUT_BYTES + 8) + 1;
    localparam int XW  = (SW > 20) ? SW : 20;

    localparam logic [XW-1:0] AB_X = XW'(ASSEMBLY_BYTES);
    localparam logic [XW-1:0] OB_X = XW'(OUTPUT_BYTES);

    // sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_RD      = 5'd1;
    localparam logic [4:0] S_H0      = 5'd2;
    localparam logic [4:0] S_H4      = 5'd3;
    localparam logic [4:0] S_H5      = 5'd4;
    localparam logic [4:0] S_H6      = 5'd5;
    localparam logic [4:0] S_H7      = 5'd6;
    localparam logic [4:0] S_H8      = 5'd7;
    localparam logic [4:0] S_X3      = 5'd8;
    localparam logic [4:0] S_X4      = 5'd9;
    localparam logic [4:0] S_PAD     = 5'd10;
    localparam logic [4:0] S_PAD2    = 5'd11;
    localparam logic [4:0] S_T0      = 5'd12;
    localparam logic [4:0] S_T1      = 5'd13;
    localparam logic [4:0] S_T2      = 5'd14;
    localparam logic [4:0] S_DEC     = 5'd15;
    localparam logic [4:0] S_CP_ASM  = 5'd16;
    localparam logic [4:0] S_CP_SC   = 5'd17;
    localparam logic [4:0] S_CP_HDR  = 5'd18;
    localparam logic [4:0] S_CP_DG   = 5'd19;

    // submodule connections
    logic            dg_we, dg_clear, dg_over;
    logic [DAW-1:0]  dg_rd_addr;
    logic [7:0]      dg_rdata;
    logic [LW-1:0]   dg_size;
    logic            ob_wr_en, ob_push, ob_rd_req;
    logic [7:0]      ob_wr_byte, ob_rd_byte;
    logic [OUW-1:0]  ob_push_len, ob_used;
    unit_meta_t      ob_push_meta, ob_rd_meta;
    logic [QCW-1:0]  ob_count;
    logic            ob_rd_first, ob_rd_last;

    // assembly store
    logic [7:0]      asm_mem [ASSEMBLY_BYTES];
    logic [7:0]      asm_rdata_reg;
    logic            asm_we;
    logic [7:0]      asm_wr_byte;
    logic [AAW-1:0]  asm_rd_addr;

    // control and parse registers
    logic [4:0]      state_reg, state_next;
    logic            codec_mode_reg, codec_mode_next;
    logic [ALW-1:0]  asm_len_reg, asm_len_next;
    logic            sps_held_reg, sps_held_next;
    logic            frag_open_reg, frag_open_next;
    logic [7:0]      asm4_reg, asm4_next;
    logic [7:0]      b0_reg, b0_next;
    logic [31:0]     ts_reg, ts_next;
    logic [7:0]      xhi_reg, xhi_next;
    logic [XW-1:0]   off_reg, off_next;
    logic [LW-1:0]   p_reg, p_next;
    logic [LW-1:0]   plen_reg, plen_next;
    logic [7:0]      t0_reg, t0_next;
    logic [7:0]      t1_reg, t1_next;

    // copy job registers
    logic            job_dst_out_reg, job_dst_out_next;
    logic [ALW-1:0]  job_alen_reg, job_alen_next;
    logic            job_sc_reg, job_sc_next;
    logic            job_hdr_reg, job_hdr_next;
    logic [7:0]      job_hbyte_reg, job_hbyte_next;
    logic [LW-1:0]   job_pos_reg, job_pos_next;
    logic [LW-1:0]   job_len_reg, job_len_next;
    logic [ALW-1:0]  asm_wp_reg, asm_wp_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            pv_reg, pv_next;

    // result registers
    logic            done_reg, done_next;
    logic [2:0]      res_status_reg, res_status_next;
    logic            res_valid_reg, res_valid_next;
    logic [7:0]      res_byte_reg, res_byte_next;
    logic            res_first_reg, res_first_next;
    logic            res_last_reg, res_last_next;
    logic            res_key_reg, res_key_next;
    logic [31:0]     res_ts_reg, res_ts_next;

    // combinational helpers
    logic            fin;
    logic [2:0]      fin_status;
    logic            cp_we;
    logic [7:0]      cp_byte;
    logic [XW-1:0]   off0, end_x, pad_x, size_x, plen_x, total_x;
    logic [13:0]     au_len;
    logic [4:0]      nal_type;
    logic [7:0]      fu_hdr_byte;
    logic            job_go, job_emit, job_sc, job_hdr, job_key, q_full;
    logic [ALW-1:0]  job_alen, job_wp;
    logic [LW-1:0]   job_pos, job_len;
    logic            next_is_sc_hdr;

    rhad_dgram #(
        .MAX_DATAGRAM (MAX_DATAGRAM)
    ) u_dgram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (dg_we),
        .wr_byte (data_byte),
        .clear   (dg_clear),
        .rd_addr (dg_rd_addr),
        .rd_data (dg_rdata),
        .size    (dg_size),
        .over    (dg_over)
    );

    rhad_outbuf #(
        .OUTPUT_BYTES (OUTPUT_BYTES),
        .OUTPUT_UNITS (OUTPUT_UNITS)
    ) u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (ob_wr_en),
        .wr_byte   (ob_wr_byte),
        .push      (ob_push),
        .push_len  (ob_push_len),
        .push_meta (ob_push_meta),
        .rd_req    (ob_rd_req),
        .count     (ob_count),
        .used      (ob_used),
        .rd_byte   (ob_rd_byte),
        .rd_first  (ob_rd_first),
        .rd_last   (ob_rd_last),
        .rd_meta   (ob_rd_meta)
    );

    // parse arithmetic
    assign size_x      = XW'(dg_size);
    assign off0        = XW'(RTP_FIXED_HDR) + XW'({b0_reg[3:0], 2'b00});
    assign pad_x       = XW'(dg_rdata);
    assign end_x       = ((b0_reg & RTP_PAD_BIT) != 8'h00) ? size_x - pad_x : size_x;
    assign plen_x      = XW'(plen_reg);
    assign au_len      = 14'(((17'({t0_reg, t1_reg}) + 17'd7) >> 3));
    assign nal_type    = t0_reg[4:0];
    assign fu_hdr_byte = (t0_reg & NAL_NRI_MASK) | (t1_reg & NAL_TYPE_MASK);
    assign total_x     = XW'(job_alen) + (job_sc ? XW'(4) : XW'(0)) + XW'(job_len);
    assign q_full      = (ob_count >= QCW'(OUTPUT_UNITS)) ||
                         (total_x > OB_X - XW'(ob_used));

    // copy destination routing
    assign ob_wr_en    = cp_we && job_dst_out_reg;
    assign ob_wr_byte  = cp_byte;
    assign asm_we      = cp_we && !job_dst_out_reg;
    assign asm_wr_byte = cp_byte;
    assign asm_rd_addr = cnt_reg[AAW-1:0];
    assign ob_push_len = OUW'(total_x);
    assign ob_push_meta.key = job_key;
    assign ob_push_meta.ts  = ts_reg;
    assign next_is_sc_hdr   = job_sc_reg || job_hdr_reg;

    // unit decision: what the parsed payload turns into
    always_comb
    begin
        job_go   = 1'b0;
        job_emit = 1'b0;
        job_sc   = 1'b0;
        job_hdr  = 1'b0;
        job_key  = 1'b0;
        job_alen = '0;
        job_wp   = '0;
        job_pos  = p_reg;
        job_len  = plen_reg;
        if (state_reg == S_DEC)
        begin
            if (codec_mode_reg == MODE_AAC)
            begin
                if (plen_reg >= LW'(2) && plen_x > XW'(2) + XW'(au_len))
                begin
                    job_go   = 1'b1;
                    job_emit = 1'b1;
                    job_key  = 1'b1;
                    job_pos  = LW'(XW'(p_reg) + XW'(2) + XW'(au_len));
                    job_len  = LW'(plen_x - XW'(2) - XW'(au_len));
                end
            end
            else if (nal_type >= 5'd1 && nal_type <= NAL_SINGLE_MAX)
            begin
                if (nal_type == NAL_SPS)
                begin
                    if (plen_x + XW'(4) <= AB_X)
                    begin
                        job_go = 1'b1;
                        job_sc = 1'b1;
                    end
                end
                else if (nal_type == NAL_PPS)
                begin
                    if (sps_held_reg && asm_len_reg != '0)
                    begin
                        job_go   = 1'b1;
                        job_emit = 1'b1;
                        job_sc   = 1'b1;
                        job_key  = 1'b1;
                        job_alen = asm_len_reg;
                    end
                end
                else
                begin
                    job_go   = 1'b1;
                    job_emit = 1'b1;
                    job_sc   = 1'b1;
                    job_key  = (nal_type == NAL_IDR);
                end
            end
            else if (nal_type == NAL_FU_A && plen_reg >= LW'(2))
            begin
                job_pos = p_reg + LW'(2);
                job_len = plen_reg - LW'(2);
                if ((t1_reg & FU_START_BIT) != 8'h00)
                begin
                    if (plen_x + XW'(3) <= AB_X)
                    begin
                        job_go  = 1'b1;
                        job_sc  = 1'b1;
                        job_hdr = 1'b1;
                    end
                end
                else if ((t1_reg & FU_END_BIT) != 8'h00)
                begin
                    if (frag_open_reg)
                    begin
                        job_go   = 1'b1;
                        job_emit = 1'b1;
                        job_alen = asm_len_reg;
                        job_key  = (asm4_reg[4:0] == NAL_IDR) ||
                                   (asm4_reg[4:0] == NAL_SPS);
                    end
                end
                else if (frag_open_reg &&
                         XW'(asm_len_reg) + plen_x - XW'(2) <= AB_X)
                begin
                    job_go = 1'b1;
                    job_wp = asm_len_reg;
                end
            end
        end
    end

    // main sequencer
    always_comb
    begin
        state_next       = state_reg;
        codec_mode_next  = codec_mode_reg;
        asm_len_next     = asm_len_reg;
        sps_held_next    = sps_held_reg;
        frag_open_next   = frag_open_reg;
        asm4_next        = asm4_reg;
        b0_next          = b0_reg;
        ts_next          = ts_reg;
        xhi_next         = xhi_reg;
        off_next         = off_reg;
        p_next           = p_reg;
        plen_next        = plen_reg;
        t0_next          = t0_reg;
        t1_next          = t1_reg;
        job_dst_out_next = job_dst_out_reg;
        job_alen_next    = job_alen_reg;
        job_sc_next      = job_sc_reg;
        job_hdr_next     = job_hdr_reg;
        job_hbyte_next   = job_hbyte_reg;
        job_pos_next     = job_pos_reg;
        job_len_next     = job_len_reg;
        asm_wp_next      = asm_wp_reg;
        cnt_next         = cnt_reg;
        pv_next          = pv_reg;
        done_next        = 1'b0;
        res_status_next  = res_status_reg;
        res_valid_next   = res_valid_reg;
        res_byte_next    = res_byte_reg;
        res_first_next   = res_first_reg;
        res_last_next    = res_last_reg;
        res_key_next     = res_key_reg;
        res_ts_next      = res_ts_reg;
        fin              = 1'b0;
        fin_status       = ST_OK;
        dg_we            = 1'b0;
        dg_rd_addr       = '0;
        ob_push          = 1'b0;
        ob_rd_req        = 1'b0;
        cp_we            = 1'b0;
        cp_byte          = 8'h00;

        if (cfg_valid)
            codec_mode_next = cfg_data;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_WRITE)
                    begin
                        dg_we = 1'b1;
                        if (last_byte)
                            state_next = S_H0;
                        else
                            fin = 1'b1;
                    end
                    else if (ob_count == '0)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_EMPTY;
                    end
                    else
                    begin
                        ob_rd_req  = 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                done_next       = 1'b1;
                res_status_next = ST_OK;
                res_valid_next  = 1'b1;
                res_byte_next   = ob_rd_byte;
                res_first_next  = ob_rd_first;
                res_last_next   = ob_rd_last;
                res_key_next    = ob_rd_meta.key;
                res_ts_next     = ob_rd_meta.ts;
                state_next      = S_IDLE;
            end
            // fixed header reads
            S_H0:
            begin
                if (dg_over || dg_size <= LW'(RTP_FIXED_HDR))
                begin
                    fin        = 1'b1;
                    fin_status = ST_MALFORMED;
                end
                else
                    state_next = S_H4;
            end
            S_H4:
            begin
                dg_rd_addr = DAW'(4);
                b0_next    = dg_rdata;
                state_next = S_H5;
            end
            S_H5:
            begin
                dg_rd_addr     = DAW'(5);
                ts_next[31:24] = dg_rdata;
                state_next     = S_H6;
            end
            S_H6:
            begin
                dg_rd_addr     = DAW'(6);
                ts_next[23:16] = dg_rdata;
                state_next     = S_H7;
            end
            S_H7:
            begin
                dg_rd_addr     = DAW'(7);
                ts_next[15:8]  = dg_rdata;
                state_next     = S_H8;
            end
            S_H8:
            begin
                ts_next[7:0] = dg_rdata;
                off_next     = off0;
                if ((b0_reg & RTP_EXT_BIT) != 8'h00)
                begin
                    if (off0 + XW'(4) > size_x)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_MALFORMED;
                    end
                    else
                    begin
                        dg_rd_addr = DAW'(off0 + XW'(2));
                        state_next = S_X3;
                    end
                end
                else
                    state_next = S_PAD;
            end
            // header extension length
            S_X3:
            begin
                dg_rd_addr = DAW'(off_reg + XW'(3));
                xhi_next   = dg_rdata;
                state_next = S_X4;
            end
            S_X4:
            begin
                off_next   = off_reg + XW'(4) + XW'({xhi_reg, dg_rdata, 2'b00});
                state_next = S_PAD;
            end
            // padding and payload bounds
            S_PAD:
            begin
                dg_rd_addr = DAW'(size_x - XW'(1));
                state_next = S_PAD2;
            end
            S_PAD2:
            begin
                if (((b0_reg & RTP_PAD_BIT) != 8'h00 && pad_x > size_x) ||
                    off_reg >= end_x)
                begin
                    fin        = 1'b1;
                    fin_status = ST_MALFORMED;
                end
                else
                begin
                    p_next     = LW'(off_reg);
                    plen_next  = LW'(end_x - off_reg);
                    state_next = S_T0;
                end
            end
            // first two payload bytes
            S_T0:
            begin
                dg_rd_addr = DAW'(p_reg);
                state_next = S_T1;
            end
            S_T1:
            begin
                dg_rd_addr = DAW'(p_reg + LW'(1));
                t0_next    = dg_rdata;
                state_next = S_T2;
            end
            S_T2:
            begin
                t1_next    = dg_rdata;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                fin        = 1'b1;
                fin_status = ST_OK;
                if (codec_mode_reg == MODE_AAC)
                begin
                    if (!job_go)
                        fin_status = ST_MALFORMED;
                end
                else if (nal_type >= 5'd1 && nal_type <= NAL_SINGLE_MAX)
                begin
                    frag_open_next = 1'b0;
                    if (nal_type == NAL_SPS)
                    begin
                        if (job_go)
                        begin
                            asm_len_next  = ALW'(plen_x + XW'(4));
                            sps_held_next = 1'b1;
                            asm4_next     = t0_reg;
                        end
                        else
                        begin
                            asm_len_next  = '0;
                            sps_held_next = 1'b0;
                            fin_status    = ST_OVERFLOW;
                        end
                    end
                    else
                    begin
                        asm_len_next  = '0;
                        sps_held_next = 1'b0;
                    end
                end
                else if (nal_type == NAL_FU_A)
                begin
                    sps_held_next = 1'b0;
                    if (plen_reg < LW'(2))
                        fin_status = ST_MALFORMED;
                    else if ((t1_reg & FU_START_BIT) != 8'h00)
                    begin
                        if (job_go)
                        begin
                            asm_len_next   = ALW'(plen_x + XW'(3));
                            frag_open_next = 1'b1;
                            asm4_next      = fu_hdr_byte;
                        end
                        else
                        begin
                            asm_len_next   = '0;
                            frag_open_next = 1'b0;
                            fin_status     = ST_OVERFLOW;
                        end
                    end
                    else if ((t1_reg & FU_END_BIT) != 8'h00)
                    begin
                        frag_open_next = 1'b0;
                        asm_len_next   = '0;
                    end
                    else if (!frag_open_reg)
                        asm_len_next = '0;
                    else if (job_go)
                        asm_len_next = ALW'(XW'(asm_len_reg) + plen_x - XW'(2));
                    else
                        fin_status = ST_OVERFLOW;
                end
                else
                begin
                    sps_held_next  = 1'b0;
                    frag_open_next = 1'b0;
                    asm_len_next   = '0;
                    fin_status     = ST_UNSUPPORTED;
                end

                // start the copy, or drop a unit that does not fit
                if (job_go)
                begin
                    if (job_emit && q_full)
                        fin_status = ST_FULL;
                    else
                    begin
                        fin              = 1'b0;
                        ob_push          = job_emit;
                        job_dst_out_next = job_emit;
                        job_alen_next    = job_alen;
                        job_sc_next      = job_sc;
                        job_hdr_next     = job_hdr;
                        job_hbyte_next   = fu_hdr_byte;
                        job_pos_next     = job_pos;
                        job_len_next     = job_len;
                        asm_wp_next      = job_wp;
                        cnt_next         = '0;
                        pv_next          = 1'b0;
                        state_next       = S_CP_ASM;
                    end
                end
            end
            // assembly prefix into the output store
            S_CP_ASM:
            begin
                cp_we   = pv_reg;
                cp_byte = asm_rdata_reg;
                if (CW'(cnt_reg) < CW'(job_alen_reg))
                begin
                    cnt_next = cnt_reg + 1'b1;
                    pv_next  = 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                    if (!pv_reg)
                    begin
                        cnt_next = '0;
                        if (job_sc_reg)
                            state_next = S_CP_SC;
                        else if (next_is_sc_hdr)
                            state_next = S_CP_HDR;
                        else
                            state_next = S_CP_DG;
                    end
                end
            end
            // annex b start code
            S_CP_SC:
            begin
                cp_we    = 1'b1;
                cp_byte  = (cnt_reg == CW'(3)) ? 8'h01 : 8'h00;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(3))
                begin
                    cnt_next   = '0;
                    state_next = job_hdr_reg ? S_CP_HDR : S_CP_DG;
                end
            end
            // rebuilt nal header of a fragmented unit
            S_CP_HDR:
            begin
                cp_we      = 1'b1;
                cp_byte    = job_hbyte_reg;
                state_next = S_CP_DG;
            end
            // datagram payload slice
            S_CP_DG:
            begin
                dg_rd_addr = DAW'(job_pos_reg + LW'(cnt_reg));
                cp_we      = pv_reg;
                cp_byte    = dg_rdata;
                if (CW'(cnt_reg) < CW'(job_len_reg))
                begin
                    cnt_next = cnt_reg + 1'b1;
                    pv_next  = 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                    if (!pv_reg)
                        fin = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (asm_we)
            asm_wp_next = asm_wp_reg + 1'b1;

        // status-only result
        if (fin)
        begin
            done_next       = 1'b1;
            res_status_next = fin_status;
            res_valid_next  = 1'b0;
            res_byte_next   = 8'h00;
            res_first_next  = 1'b0;
            res_last_next   = 1'b0;
            res_key_next    = 1'b0;
            res_ts_next     = 32'h0;
            state_next      = S_IDLE;
        end
    end

    // datagram is cleared when its parse ends
    assign dg_clear = fin && (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            codec_mode_reg <= MODE_H264;
            asm_len_reg    <= '0;
            sps_held_reg   <= 1'b0;
            frag_open_reg  <= 1'b0;
            cnt_reg        <= '0;
            pv_reg         <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            codec_mode_reg <= codec_mode_next;
            asm_len_reg    <= asm_len_next;
            sps_held_reg   <= sps_held_next;
            frag_open_reg  <= frag_open_next;
            cnt_reg        <= cnt_next;
            pv_reg         <= pv_next;
            done_reg       <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        asm4_reg        <= asm4_next;
        b0_reg          <= b0_next;
        ts_reg          <= ts_next;
        xhi_reg         <= xhi_next;
        off_reg         <= off_next;
        p_reg           <= p_next;
        plen_reg        <= plen_next;
        t0_reg          <= t0_next;
        t1_reg          <= t1_next;
        job_dst_out_reg <= job_dst_out_next;
        job_alen_reg    <= job_alen_next;
        job_sc_reg      <= job_sc_next;
        job_hdr_reg     <= job_hdr_next;
        job_hbyte_reg   <= job_hbyte_next;
        job_pos_reg     <= job_pos_next;
        job_len_reg     <= job_len_next;
        asm_wp_reg      <= asm_wp_next;
        res_status_reg  <= res_status_next;
        res_valid_reg   <= res_valid_next;
        res_byte_reg    <= res_byte_next;
        res_first_reg   <= res_first_next;
        res_last_reg    <= res_last_next;
        res_key_reg     <= res_key_next;
        res_ts_reg      <= res_ts_next;
    end

    // assembly memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (asm_we)
            asm_mem[asm_wp_reg[AAW-1:0]] <= asm_wr_byte;
        asm_rdata_reg <= asm_mem[asm_rd_addr];
    end

    assign busy           = (state_reg != S_IDLE);
    assign cfg_ready      = 1'b1;
    assign done           = done_reg;
    assign status         = res_status_reg;
    assign out_valid      = done_reg && res_valid_reg;
    assign out_byte       = res_byte_reg;
    assign out_first      = res_first_reg;
    assign out_last       = res_last_reg;
    assign key_unit       = res_key_reg;
    assign unit_timestamp = res_ts_reg;

    // a result only shows once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while sequencer busy");

    // read of an empty queue answers at once with the empty status
    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_READ && ob_count == '0)
        |=> (done && status == ST_EMPTY && !out_valid))
        else $error("empty read not reported");

    // queue occupancy stays within its depth
    a_queue_depth: assert property (@(posedge clk) disable iff (!rst_n)
        ob_count <= QCW'(OUTPUT_UNITS))
        else $error("unit queue over depth");

    // assembly length never passes the store size
    a_asm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        XW'(asm_len_reg) <= AB_X)
        else $error("assembly length over store size");

    // a unit byte transfer carries the ok status
    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK))
        else $error("unit byte with error status");

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench of the rtp h.264 / aac depacketizer
`timescale 1ns / 1ps

module tb_top;
    import rhad_pkg::*;

    localparam int MAXD        = 2048;
    localparam int ASMB        = 16384;
    localparam int OUTB        = 32768;
    localparam int UNITS       = 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RAND_ITEMS  = 1750;

    typedef struct packed {
        logic [2:0]  status;
        logic        valid;
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic        key;
        logic [31:0] ts;
    } step_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        done;
    logic [2:0]  status;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        out_first;
    logic        out_last;
    logic        key_unit;
    logic [31:0] unit_timestamp;

    rtp_h264_aac_depacketizer i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .data_byte(data_byte), .last_byte(last_byte), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_data(cfg_data), .done(done),
        .status(status), .out_valid(out_valid), .out_byte(out_byte),
        .out_first(out_first), .out_last(out_last), .key_unit(key_unit),
        .unit_timestamp(unit_timestamp)
    );

    // predicted depacketizer state
    logic        mode_q;
    logic [7:0]  dg_mem [MAXD];
    int          dg_len;
    bit          dg_over;
    logic [7:0]  asm_mem [ASMB];
    int          asm_len;
    bit          sps_held;
    bit          frag_open;
    logic [7:0]  out_mem [OUTB];
    int          out_wr;
    int          out_used;
    int          uq_start [UNITS];
    int          uq_len [UNITS];
    bit          uq_key [UNITS];
    logic [31:0] uq_ts [UNITS];
    int          uq_head;
    int          uq_count;
    int          rd_off;

    step_result_t predicted_results [$];
    logic [7:0]   pkt [$];
    int           err_count;
    int           cycle_count;
    int           burst_left;
    int           item_count;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // queue one finished unit: assembly prefix, optional start code, payload slice
    function automatic logic [2:0] queue_unit(int alen, bit sc, int dpos, int dlen,
                                              bit key, logic [31:0] ts);
        int total;
        int slot;
        total = alen + (sc ? 4 : 0) + dlen;
        if (uq_count >= UNITS || total > OUTB - out_used)
            return ST_FULL;
        slot = (uq_head + uq_count) % UNITS;
        uq_start[slot] = out_wr;
        uq_len[slot] = total;
        uq_key[slot] = key;
        uq_ts[slot] = ts;
        for (int i = 0; i < total; i++)
        begin
            if (i < alen)
                out_mem[out_wr] = asm_mem[i];
            else if (sc && i < alen + 4)
                out_mem[out_wr] = (i == alen + 3) ? 8'd1 : 8'd0;
            else
                out_mem[out_wr] = dg_mem[dpos + i - alen - (sc ? 4 : 0)];
            out_wr = (out_wr + 1) % OUTB;
        end
        out_used += total;
        uq_count++;
        return ST_OK;
    endfunction

    // parse the finished datagram and update the predicted state
    function automatic logic [2:0] parse_datagram();
        int          size;
        int          b0;
        longint      off;
        longint      endp;
        int          p;
        int          plen;
        int          typ;
        int          hdr;
        int          au;
        int          nt;
        logic [31:0] ts;
        logic [2:0]  st;
        size = dg_len;
        if (dg_over || size <= RTP_FIXED_HDR)
            return ST_MALFORMED;
        b0 = dg_mem[0];
        ts = {dg_mem[4], dg_mem[5], dg_mem[6], dg_mem[7]};
        off = RTP_FIXED_HDR + (b0 & RTP_CC_MASK) * 4;
        if (b0 & RTP_EXT_BIT)
        begin
            if (off + 4 > size)
                return ST_MALFORMED;
            off = off + 4 + ((int'(dg_mem[off + 2]) << 8) | int'(dg_mem[off + 3])) * 4;
        end
        endp = size;
        if (b0 & RTP_PAD_BIT)
        begin
            if (int'(dg_mem[size - 1]) > endp)
                return ST_MALFORMED;
            endp = endp - dg_mem[size - 1];
        end
        if (off >= endp)
            return ST_MALFORMED;
        p = int'(off);
        plen = int'(endp - off);

        // aac: skip the au-header section
        if (mode_q == MODE_AAC)
        begin
            if (plen < 2)
                return ST_MALFORMED;
            au = (((int'(dg_mem[p]) << 8) | int'(dg_mem[p + 1])) + 7) / 8;
            if (plen <= 2 + au)
                return ST_MALFORMED;
            return queue_unit(0, 0, p + 2 + au, plen - 2 - au, 1, ts);
        end

        typ = dg_mem[p] & NAL_TYPE_MASK;
        // single nal unit
        if (typ >= 1 && typ <= NAL_SINGLE_MAX)
        begin
            st = ST_OK;
            frag_open = 0;
            if (typ == NAL_SPS)
            begin
                if (plen + 4 > ASMB)
                begin
                    sps_held = 0;
                    asm_len = 0;
                    return ST_OVERFLOW;
                end
                asm_mem[0] = 8'h00; asm_mem[1] = 8'h00;
                asm_mem[2] = 8'h00; asm_mem[3] = 8'h01;
                for (int i = 0; i < plen; i++)
                    asm_mem[4 + i] = dg_mem[p + i];
                asm_len = plen + 4;
                sps_held = 1;
                return ST_OK;
            end
            if (typ == NAL_PPS)
            begin
                if (sps_held && asm_len > 0)
                    st = queue_unit(asm_len, 1, p, plen, 1, ts);
            end
            else
                st = queue_unit(0, 1, p, plen, typ == NAL_IDR, ts);
            sps_held = 0;
            asm_len = 0;
            return st;
        end
        // fu-a fragment
        if (typ == NAL_FU_A)
        begin
            sps_held = 0;
            if (plen < 2)
                return ST_MALFORMED;
            hdr = dg_mem[p + 1];
            if (hdr & FU_START_BIT)
            begin
                if (plen + 3 > ASMB)
                begin
                    frag_open = 0;
                    asm_len = 0;
                    return ST_OVERFLOW;
                end
                asm_mem[0] = 8'h00; asm_mem[1] = 8'h00;
                asm_mem[2] = 8'h00; asm_mem[3] = 8'h01;
                asm_mem[4] = (dg_mem[p] & NAL_NRI_MASK) | (hdr[7:0] & NAL_TYPE_MASK);
                for (int i = 0; i < plen - 2; i++)
                    asm_mem[5 + i] = dg_mem[p + 2 + i];
                asm_len = plen + 3;
                frag_open = 1;
                return ST_OK;
            end
            if (hdr & FU_END_BIT)
            begin
                st = ST_OK;
                if (frag_open)
                begin
                    nt = asm_mem[4] & NAL_TYPE_MASK;
                    st = queue_unit(asm_len, 0, p + 2, plen - 2,
                                    nt == NAL_IDR || nt == NAL_SPS, ts);
                end
                frag_open = 0;
                asm_len = 0;
                return st;
            end
            if (!frag_open)
            begin
                asm_len = 0;
                return ST_OK;
            end
            if (asm_len + plen - 2 > ASMB)
                return ST_OVERFLOW;
            for (int i = 0; i < plen - 2; i++)
                asm_mem[asm_len + i] = dg_mem[p + 2 + i];
            asm_len += plen - 2;
            return ST_OK;
        end
        sps_held = 0;
        frag_open = 0;
        asm_len = 0;
        return ST_UNSUPPORTED;
    endfunction

    // predict the result of one accepted command
    function automatic void depacketize_step(logic c, logic [7:0] d, logic l);
        step_result_t r;
        int           h;
        r = '0;
        if (c == CMD_WRITE)
        begin
            if (dg_len < MAXD)
            begin
                dg_mem[dg_len] = d;
                dg_len++;
            end
            else
                dg_over = 1;
            if (l)
            begin
                r.status = parse_datagram();
                dg_len = 0;
                dg_over = 0;
            end
        end
        else if (uq_count == 0)
            r.status = ST_EMPTY;
        else
        begin
            h = uq_head;
            r.status = ST_OK;
            r.valid = 1'b1;
            r.data = out_mem[(uq_start[h] + rd_off) % OUTB];
            r.first = (rd_off == 0);
            r.last = (rd_off + 1 >= uq_len[h]);
            r.key = uq_key[h];
            r.ts = uq_ts[h];
            if (r.last)
            begin
                out_used = (out_used >= uq_len[h]) ? out_used - uq_len[h] : 0;
                uq_head = (h + 1) % UNITS;
                uq_count--;
                rd_off = 0;
            end
            else
                rd_off++;
        end
        predicted_results.push_back(r);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (err_count < 30)
            $display("mismatch %s: got %0h expected %0h at cycle %0d",
                     what, got, want, cycle_count);
        err_count++;
    endtask

    // result checker and run limit
    always @(posedge clk)
    begin
        step_result_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        if (rst_n && done)
        begin
            if (predicted_results.size() == 0)
                report_mismatch("unexpected result", 32'(status), 32'h0);
            else
            begin
                want = predicted_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (out_valid !== want.valid)
                    report_mismatch("out_valid", 32'(out_valid), 32'(want.valid));
                if (out_byte !== want.data)
                    report_mismatch("out_byte", 32'(out_byte), 32'(want.data));
                if (out_first !== want.first)
                    report_mismatch("out_first", 32'(out_first), 32'(want.first));
                if (out_last !== want.last)
                    report_mismatch("out_last", 32'(out_last), 32'(want.last));
                if (key_unit !== want.key)
                    report_mismatch("key_unit", 32'(key_unit), 32'(want.key));
                if (unit_timestamp !== want.ts)
                    report_mismatch("unit_timestamp", unit_timestamp, want.ts);
            end
        end
    end

    // one command transfer, with bursts and random gaps; called at a falling edge
    task automatic send_item(logic c, logic [7:0] d, logic l);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        start <= 1'b1;
        cmd <= c;
        data_byte <= d;
        last_byte <= l;
        do
            @(posedge clk);
        while (busy);
        depacketize_step(c, d, l);
        item_count++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (predicted_results.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_mode(logic m);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        mode_q = m;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pkt();
        foreach (pkt[i])
            send_item(CMD_WRITE, pkt[i], i == pkt.size() - 1);
    endtask

    task automatic read_bytes(int n);
        repeat (n)
            send_item(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic drain_units();
        while (uq_count > 0)
            send_item(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // packet builders
    function automatic void add_random(int n);
        repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void start_rtp(int cc, bit ext, int ext_words);
        pkt.delete();
        pkt.push_back(8'h80 | (ext ? RTP_EXT_BIT : 8'h00) | cc[3:0]);
        add_random(11 + cc * 4);
        if (ext)
        begin
            add_random(2);
            pkt.push_back(ext_words[15:8]);
            pkt.push_back(ext_words[7:0]);
            add_random(ext_words * 4);
        end
    endfunction

    function automatic void start_rtp_rand();
        if ($urandom_range(0, 4) == 0)
            start_rtp($urandom_range(0, 15), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 3));
        else
            start_rtp($urandom_range(0, 1), $urandom_range(0, 5) == 0, $urandom_range(0, 2));
    endfunction

    function automatic void add_padding(int padn);
        if (padn > 0)
        begin
            add_random(padn - 1);
            pkt.push_back(padn[7:0]);
            pkt[0] = pkt[0] | RTP_PAD_BIT;
        end
    endfunction

    task automatic send_single(logic [4:0] typ, int n);
        start_rtp_rand();
        pkt.push_back({3'($urandom_range(0, 7)), 5'd0} | {3'b000, typ});
        add_random(n - 1);
        add_padding(($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0);
        send_pkt();
    endtask

    task automatic send_fu(logic [7:0] fu_hdr, int n);
        start_rtp_rand();
        pkt.push_back({3'($urandom_range(0, 7)), 5'd0} | {3'b000, NAL_FU_A});
        pkt.push_back(fu_hdr);
        add_random(n);
        send_pkt();
    endtask

    task automatic send_aac(int au_bits, int n);
        start_rtp_rand();
        pkt.push_back(au_bits[15:8]);
        pkt.push_back(au_bits[7:0]);
        add_random((au_bits + 7) / 8 + n);
        add_padding(($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
        send_pkt();
    endtask

    // single nal units, header stripping and reads from an empty store
    task automatic test_single_units();
        write_mode(MODE_H264);
        read_bytes(2);
        send_single(5'd1, 1);
        send_single(NAL_IDR, 20);
        send_single(NAL_SINGLE_MAX, 5);
        start_rtp(15, 1, 3);
        pkt.push_back(8'h65);
        add_random(7);
        send_pkt();
        // twelve bytes only, then a one-byte payload
        start_rtp(0, 0, 0);
        send_pkt();
        start_rtp(0, 0, 0);
        pkt.push_back(8'hff);
        send_pkt();
        drain_units();
    endtask

    // sps held and merged with the next pps; orphan pps
    task automatic test_parameter_sets();
        send_single(NAL_SPS, 10);
        send_single(NAL_PPS, 4);
        send_single(NAL_PPS, 4);
        send_single(NAL_SPS, 6);
        send_single(5'd1, 3);
        send_single(NAL_PPS, 2);
        drain_units();
    endtask

    // fu-a reassembly and its broken forms
    task automatic test_fragments();
        send_fu(FU_START_BIT | NAL_IDR, 8);
        send_fu(8'h05, 6);
        send_fu(FU_END_BIT | NAL_IDR, 3);
        send_fu(FU_START_BIT | FU_END_BIT | NAL_SPS, 4);
        send_fu(FU_END_BIT | 8'h01, 0);
        send_fu(8'h01, 5);
        send_fu(FU_END_BIT | 8'h01, 2);
        // fu-a with only the indicator byte
        start_rtp(0, 0, 0);
        pkt.push_back(8'h7c);
        send_pkt();
        drain_units();
    endtask

    task automatic test_unsupported_types();
        send_fu(FU_START_BIT | 8'h01, 4);
        send_single(5'd0, 3);
        send_fu(FU_END_BIT | 8'h01, 2);
        send_single(5'd24, 3);
        send_single(5'd29, 3);
        send_single(5'd31, 2);
        drain_units();
    endtask

    // extension past the end, padding too long, payload eaten by padding
    task automatic test_header_errors();
        start_rtp(0, 0, 0);
        pkt[0] = pkt[0] | RTP_EXT_BIT;
        pkt.push_back(8'h41);
        add_random(2);
        send_pkt();
        start_rtp(0, 0, 0);
        pkt.push_back(8'h41);
        pkt.push_back(8'hc8);
        pkt[0] = pkt[0] | RTP_PAD_BIT;
        send_pkt();
        start_rtp(0, 0, 0);
        pkt.push_back(8'h41);
        add_padding(3);
        pkt[pkt.size() - 1] = 8'd4;
        send_pkt();
        start_rtp(0, 0, 0);
        pkt.push_back(8'h41);
        pkt.push_back(8'h00);
        pkt[0] = pkt[0] | RTP_PAD_BIT;
        send_pkt();
        drain_units();
    endtask

    task automatic test_aac();
        write_mode(MODE_AAC);
        send_aac(16, 10);
        send_aac(0, 1);
        send_aac(13, 3);
        send_aac(8, 0);
        start_rtp(0, 0, 0);
        pkt.push_back(8'h00);
        send_pkt();
        drain_units();
        write_mode(MODE_H264);
    endtask

    // unit queue runs out of slots
    task automatic test_unit_full();
        repeat (UNITS + 2)
            send_single(5'd1, 3);
        drain_units();
    endtask

    // datagram longer than the store
    task automatic test_oversize();
        start_rtp(0, 0, 0);
        pkt.push_back(8'h41);
        add_random(MAXD + 50);
        send_pkt();
        send_single(5'd1, 2);
        drain_units();
    endtask

    // assembly overflow on a middle fragment, then output bytes run out
    task automatic test_store_limits();
        repeat (3)
        begin
            send_fu(FU_START_BIT | 8'h01, 2030);
            repeat (8)
                send_fu(8'h01, 2030);
            send_fu(FU_END_BIT | 8'h01, 10);
        end
        wait_idle();
        drain_units();
    endtask

    task automatic random_h264_packet();
        int r;
        int t;
        r = $urandom_range(0, 99);
        if (r < 35)
            send_single(5'($urandom_range(1, 23)),
                        ($urandom_range(0, 30) == 0) ? $urandom_range(200, 1400)
                                                     : $urandom_range(1, 40));
        else if (r < 50)
        begin
            send_single(NAL_SPS, $urandom_range(1, 30));
            send_single(($urandom_range(0, 4) == 0) ? 5'd1 : NAL_PPS, $urandom_range(1, 10));
        end
        else if (r < 75)
        begin
            t = $urandom_range(1, 23);
            if ($urandom_range(0, 9) != 0)
                send_fu(FU_START_BIT | t[7:0] |
                        (($urandom_range(0, 7) == 0) ? FU_END_BIT : 8'h00),
                        $urandom_range(0, 30));
            repeat ($urandom_range(0, 3))
                send_fu({3'b000, t[4:0]} | 8'($urandom_range(0, 1) << 5),
                        $urandom_range(0, 30));
            send_fu(FU_END_BIT | t[7:0], $urandom_range(0, 30));
        end
        else if (r < 85)
        begin
            t = $urandom_range(24, 32);
            send_single((t == 28 || t == 32) ? 5'd0 : t[4:0], $urandom_range(1, 10));
        end
        else if (r < 92)
        begin
            pkt.delete();
            add_random($urandom_range(1, 30));
            send_pkt();
        end
        else
            read_bytes($urandom_range(1, 20));
    endtask

    task automatic random_aac_packet();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            send_aac($urandom_range(0, 40), $urandom_range(1, 40));
        else if (r < 88)
            send_aac($urandom_range(0, 16), 0);
        else if (r < 93)
            send_aac($urandom_range(600, 65535), 2);
        else
        begin
            pkt.delete();
            add_random($urandom_range(1, 20));
            send_pkt();
        end
    endtask

    task automatic test_random_traffic();
        int target;
        int npkt;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_mode((phase % 2) ? MODE_AAC : MODE_H264);
            target = item_count + RAND_ITEMS / 4;
            npkt = 0;
            while (item_count < target)
            begin
                if (mode_q == MODE_AAC)
                    random_aac_packet();
                else
                    random_h264_packet();
                read_bytes($urandom_range(0, 30));
                npkt++;
                if (npkt % 8 == 0)
                    drain_units();
            end
            drain_units();
        end
    endtask

    // test sequence
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_WRITE;
        data_byte = 8'h00;
        last_byte = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = MODE_H264;
        cycle_count = 0;
        err_count = 0;
        burst_left = 0;
        item_count = 0;
        mode_q = MODE_H264;
        dg_len = 0;
        dg_over = 0;
        asm_len = 0;
        sps_held = 0;
        frag_open = 0;
        out_wr = 0;
        out_used = 0;
        uq_head = 0;
        uq_count = 0;
        rd_off = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_single_units();
        test_parameter_sets();
        test_fragments();
        test_unsupported_types();
        test_header_errors();
        test_aac();
        test_unit_full();
        test_oversize();
        test_store_limits();
        test_random_traffic();

        wait_idle();
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/rhad_pkg.sv
rtl/core/rhad_dgram.sv
rtl/core/rhad_outbuf.sv
rtl/core/rtp_h264_aac_depacketizer.sv
tb/sv/tb_top.sv
